[rtl/core/lfsd_pkg.sv]
`default_nettype none
package lfsd_pkg;

  localparam int unsigned REC_MAX = 8;
  localparam int unsigned CMD_LEN = 2;
  localparam int unsigned CFG_W   = 32;

  localparam logic [7:0]  SOF_RST     = 8'hA5;
  localparam logic [31:0] TIMEOUT_RST = 32'd100;
  localparam logic [7:0]  MAXLEN_RST  = 8'd128;
  localparam logic [15:0] INFO_RST    = 16'h0105;
  localparam logic [15:0] CLIENT_RST  = 16'h020A;

  typedef enum logic [1:0] {
    FUNC_BYTE = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FRAME = 2'd1,
    EV_ERROR = 2'd2,
    EV_READ  = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    CFG_SOF       = 3'd0,
    CFG_TIMEOUT   = 3'd1,
    CFG_MAXLEN    = 3'd2,
    CFG_INFO_ID   = 3'd3,
    CFG_CLIENT_ID = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [31:0] cur_tick;
    logic        rec_sel;
    logic [2:0]  rec_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [15:0] frame_cmd;
    logic [15:0] frame_data_len;
    logic        link_online;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    logic [7:0]  rd_data;
    logic        rd_valid;
    logic [31:0] rd_stamp;
  } out_t;

  typedef struct packed {
    logic       latch_in;
    logic       exec;
    logic       copy_rd;
    logic       copy_wr;
    logic [2:0] rd_idx;
    logic [2:0] wr_idx;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       need_fill;
    logic [3:0] copy_len;
    logic       out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/lfsd_ctrl.sv]
`default_nettype none
module lfsd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lfsd_pkg::dp_status_t status_i,
  output lfsd_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_RESULT
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic [3:0] cnt_m1;

  assign cnt_m1     = cnt_q - 4'd1;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.latch_in = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec     = (state_q == ST_EXEC);
    cmd_o.copy_rd  = (state_q == ST_COPY) && (cnt_q < status_i.copy_len);
    cmd_o.copy_wr  = (state_q == ST_COPY) && (cnt_q != 4'd0);
    cmd_o.rd_idx   = cnt_q[2:0];
    cmd_o.wr_idx   = cnt_m1[2:0];
    cmd_o.load_out = (state_q == ST_RESULT) && !status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          cnt_q <= 4'd0;
          if (status_i.need_fill) state_q <= ST_COPY;
          else                    state_q <= ST_RESULT;
        end
        ST_COPY: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == status_i.copy_len) state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!status_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/lfsd_dp.sv]
`default_nettype none
module lfsd_dp #(
  parameter int unsigned FRAME_DEPTH   = 128,
  parameter int unsigned HEADER_LEN    = 5,
  parameter int unsigned TAIL_LEN      = 2,
  parameter int unsigned LEN_FIELD_POS = 1,
  parameter int unsigned INFO_LEN      = 3,
  parameter int unsigned CLIENT_LEN    = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lfsd_pkg::in_t        in_data_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire lfsd_pkg::ctrl_cmd_t  cmd_i,
  output lfsd_pkg::dp_status_t      status_o,
  output logic                      out_valid_o,
  output lfsd_pkg::out_t            out_data_o,
  input  wire logic                 out_stall_i
);

  localparam int unsigned PW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned LW = (PW > 8) ? PW : 8;
  localparam int unsigned AW = $clog2(FRAME_DEPTH);
  localparam int unsigned PL = HEADER_LEN + lfsd_pkg::CMD_LEN;

  lfsd_pkg::in_t  in_q;
  lfsd_pkg::out_t out_q;
  logic           out_valid_q;

  // configuration
  logic [7:0]  sof_q;
  logic [31:0] timeout_q;
  logic [7:0]  max_len_q;
  logic [15:0] info_id_q;
  logic [15:0] client_id_q;

  // frame state
  logic [7:0]    mem [FRAME_DEPTH];
  logic [7:0]    mem_rd_q;
  logic [LW-1:0] pos_q, exp_q;
  logic [7:0]    byte0_q, len_lo_q, len_hi_q, cmd_lo_q, cmd_hi_q;
  logic [31:0]   last_tick_q, good_q, bad_q;
  logic          online_q;
  logic [7:0]    info_rec_q   [lfsd_pkg::REC_MAX];
  logic [7:0]    client_rec_q [lfsd_pkg::REC_MAX];
  logic [1:0]    rec_valid_q;
  logic [31:0]   rec_stamp_q [2];
  logic          fill_sel_q;

  // held result
  logic [1:0]  res_ev_q;
  logic [15:0] res_cmd_q, res_dlen_q;
  logic [7:0]  res_rd_q;
  logic        res_rv_q;
  logic [31:0] res_rs_q;

  // byte step evaluation
  logic [LW-1:0] lim, pos1, pos2, exp1, exp_t, pos_n, exp_n;
  logic          err1, len_bad, complete, info_hit, client_hit, fill;
  logic [7:0]    b, b0, len_lo_n, len_hi_n, cmd_lo_n, cmd_hi_n;
  logic [15:0]   dlen, cmdv;
  logic [17:0]   total;
  logic [1:0]    bad_inc;
  logic [1:0]    ev;
  logic          is_byte;
  logic [31:0]   tick_diff;
  logic [7:0]    rd_byte;
  logic [AW-1:0] raddr;

  assign is_byte = (lfsd_pkg::func_e'(in_q.func) == lfsd_pkg::FUNC_BYTE);
  assign b       = in_q.rx_byte;

  always_comb begin
    lim  = (LW'(max_len_q) > LW'(FRAME_DEPTH)) ? LW'(FRAME_DEPTH) : LW'(max_len_q);
    err1 = (pos_q >= lim);
    pos1 = err1 ? '0 : pos_q;
    exp1 = err1 ? '0 : exp_q;
    pos2 = pos1 + LW'(1);
    b0       = (pos1 == '0) ? b : byte0_q;
    len_lo_n = (pos1 == LW'(LEN_FIELD_POS))     ? b : len_lo_q;
    len_hi_n = (pos1 == LW'(LEN_FIELD_POS + 1)) ? b : len_hi_q;
    cmd_lo_n = (pos1 == LW'(HEADER_LEN))        ? b : cmd_lo_q;
    cmd_hi_n = (pos1 == LW'(HEADER_LEN + 1))    ? b : cmd_hi_q;
    dlen     = {len_hi_n, len_lo_n};
    cmdv     = {cmd_hi_n, cmd_lo_n};
    total    = 18'(PL + TAIL_LEN) + 18'(dlen);
    len_bad  = (exp1 == '0) && (total > 18'(lim));
    exp_t    = (exp1 == '0) ? LW'(total) : exp1;
    complete = 1'b0;
    pos_n    = '0;
    exp_n    = '0;
    bad_inc  = {1'b0, err1};
    ev       = err1 ? lfsd_pkg::EV_ERROR : lfsd_pkg::EV_NONE;
    priority if (b0 != sof_q) begin
      bad_inc = 2'(err1) + 2'd1;
      ev      = lfsd_pkg::EV_ERROR;
    end else if (pos2 < LW'(HEADER_LEN)) begin
      pos_n = pos2;
      exp_n = exp1;
    end else if (len_bad) begin
      bad_inc = 2'(err1) + 2'd1;
      ev      = lfsd_pkg::EV_ERROR;
    end else if (pos2 < exp_t) begin
      pos_n = pos2;
      exp_n = exp_t;
    end else begin
      complete = 1'b1;
      ev       = lfsd_pkg::EV_FRAME;
    end
    info_hit   = (cmdv == info_id_q) && (dlen >= 16'(INFO_LEN));
    client_hit = (cmdv == client_id_q) && (dlen >= 16'(CLIENT_LEN));
    fill       = complete && (info_hit || client_hit);
  end

  assign tick_diff = in_q.cur_tick - last_tick_q;
  assign rd_byte   = in_q.rec_sel
      ? ((32'(in_q.rec_index) < CLIENT_LEN) ? client_rec_q[in_q.rec_index] : 8'd0)
      : ((32'(in_q.rec_index) < INFO_LEN)   ? info_rec_q[in_q.rec_index]   : 8'd0);
  assign raddr     = AW'(PL) + AW'(cmd_i.rd_idx);

  assign status_o.need_fill = cmd_i.exec && is_byte && fill;
  assign status_o.copy_len  = fill_sel_q ? 4'(CLIENT_LEN) : 4'(INFO_LEN);
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_byte) mem[pos1[AW-1:0]] <= b;
    if (cmd_i.copy_rd)         mem_rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) in_q <= in_data_i;
    if (cmd_i.load_out) begin
      out_q.event_res      <= res_ev_q;
      out_q.frame_cmd      <= res_cmd_q;
      out_q.frame_data_len <= res_dlen_q;
      out_q.link_online    <= online_q;
      out_q.good_frames    <= good_q;
      out_q.bad_frames     <= bad_q;
      out_q.rd_data        <= res_rd_q;
      out_q.rd_valid       <= res_rv_q;
      out_q.rd_stamp       <= res_rs_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_q       <= lfsd_pkg::SOF_RST;
      timeout_q   <= lfsd_pkg::TIMEOUT_RST;
      max_len_q   <= lfsd_pkg::MAXLEN_RST;
      info_id_q   <= lfsd_pkg::INFO_RST;
      client_id_q <= lfsd_pkg::CLIENT_RST;
    end else if (cfg_we_i) begin
      unique case (lfsd_pkg::cfg_idx_e'(cfg_idx_i))
        lfsd_pkg::CFG_SOF:       sof_q       <= cfg_data_i[7:0];
        lfsd_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data_i;
        lfsd_pkg::CFG_MAXLEN:    max_len_q   <= cfg_data_i[7:0];
        lfsd_pkg::CFG_INFO_ID:   info_id_q   <= cfg_data_i[15:0];
        lfsd_pkg::CFG_CLIENT_ID: client_id_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      exp_q       <= '0;
      byte0_q     <= '0;
      len_lo_q    <= '0;
      len_hi_q    <= '0;
      cmd_lo_q    <= '0;
      cmd_hi_q    <= '0;
      last_tick_q <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      online_q    <= 1'b0;
      rec_valid_q <= '0;
      rec_stamp_q <= '{default: '0};
      info_rec_q   <= '{default: '0};
      client_rec_q <= '{default: '0};
      fill_sel_q  <= 1'b0;
      res_ev_q    <= '0;
      res_cmd_q   <= '0;
      res_dlen_q  <= '0;
      res_rd_q    <= '0;
      res_rv_q    <= 1'b0;
      res_rs_q    <= '0;
    end else begin
      if (cmd_i.exec) begin
        res_ev_q   <= lfsd_pkg::EV_NONE;
        res_cmd_q  <= '0;
        res_dlen_q <= '0;
        res_rd_q   <= '0;
        res_rv_q   <= 1'b0;
        res_rs_q   <= '0;
        unique case (lfsd_pkg::func_e'(in_q.func))
          lfsd_pkg::FUNC_BYTE: begin
            pos_q    <= pos_n;
            exp_q    <= exp_n;
            byte0_q  <= b0;
            len_lo_q <= len_lo_n;
            len_hi_q <= len_hi_n;
            cmd_lo_q <= cmd_lo_n;
            cmd_hi_q <= cmd_hi_n;
            bad_q    <= bad_q + 32'(bad_inc);
            res_ev_q <= ev;
            if (complete) begin
              res_cmd_q   <= cmdv;
              res_dlen_q  <= dlen;
              good_q      <= good_q + 32'd1;
              last_tick_q <= in_q.cur_tick;
              online_q    <= 1'b1;
            end
            if (fill) begin
              fill_sel_q <= !info_hit;
              rec_valid_q[!info_hit] <= 1'b1;
              rec_stamp_q[!info_hit] <= in_q.cur_tick;
            end
          end
          lfsd_pkg::FUNC_TICK: begin
            if (online_q && (tick_diff > timeout_q)) online_q <= 1'b0;
          end
          lfsd_pkg::FUNC_READ: begin
            res_ev_q <= lfsd_pkg::EV_READ;
            res_rd_q <= rd_byte;
            res_rv_q <= rec_valid_q[in_q.rec_sel];
            res_rs_q <= rec_stamp_q[in_q.rec_sel];
          end
          default: ;
        endcase
      end
      if (cmd_i.copy_wr) begin
        if (fill_sel_q) client_rec_q[cmd_i.wr_idx] <= mem_rd_q;
        else            info_rec_q[cmd_i.wr_idx]   <= mem_rd_q;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/length_framed_serial_deframer.sv]
// sequence: an accepted transaction goes through EXEC, then COPY when a frame-completing
// byte fills a record (read through the single read port of the frame store), then RESULT,
// which loads the output register once the output is not stalled; the input stays stalled
// until the sequencer is back in IDLE, so no new transaction is taken before the last is loaded
// reset: rst_ni asynchronous active low; counters, flags, records, config to defaults
`default_nettype none
module length_framed_serial_deframer #(
  parameter int unsigned FRAME_DEPTH   = 128,
  parameter int unsigned HEADER_LEN    = 5,
  parameter int unsigned TAIL_LEN      = 2,
  parameter int unsigned LEN_FIELD_POS = 1,
  parameter int unsigned INFO_LEN      = 3,
  parameter int unsigned CLIENT_LEN    = 6
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // input transactions
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lfsd_pkg::in_t  in_data_i,
  // result transactions
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output lfsd_pkg::out_t      out_data_o,
  // configuration writes
  input  wire logic           cfg_we_i,
  input  wire logic [2:0]     cfg_idx_i,
  input  wire logic [31:0]    cfg_data_i
);

  // command and status between sequencer and datapath
  lfsd_pkg::ctrl_cmd_t  cmd;
  lfsd_pkg::dp_status_t status;

  // sequencer: accept, evaluate, optional record copy, hand to output register
  lfsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: frame store memory, header capture, counters, records, output register
  lfsd_dp #(
    .FRAME_DEPTH   (FRAME_DEPTH),
    .HEADER_LEN    (HEADER_LEN),
    .TAIL_LEN      (TAIL_LEN),
    .LEN_FIELD_POS (LEN_FIELD_POS),
    .INFO_LEN      (INFO_LEN),
    .CLIENT_LEN    (CLIENT_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire

[rtl/core/lfsd_checker.sv]
`default_nettype none
module lfsd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire lfsd_pkg::out_t out_data_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted transaction keeps the input stalled in the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // accepted frame leaves the link online
  a_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == lfsd_pkg::EV_FRAME) |-> out_data_o.link_online)
    else $error("frame accepted with link offline");

  // read fields only on read replies
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != lfsd_pkg::EV_READ)
    |-> (out_data_o.rd_data == 8'd0) && !out_data_o.rd_valid && (out_data_o.rd_stamp == 32'd0))
    else $error("read fields set outside read reply");

  // frame fields only on accepted frames
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != lfsd_pkg::EV_FRAME)
    |-> (out_data_o.frame_cmd == 16'd0) && (out_data_o.frame_data_len == 16'd0))
    else $error("frame fields set outside accepted frame");

endmodule

bind length_framed_serial_deframer lfsd_checker u_lfsd_checker (.*);
`default_nettype wire

[test/length_framed_serial_deframer_checker.sv]
module length_framed_serial_deframer_checker
  import lfsd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire in_t         in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire out_t        out_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 128;
  localparam int unsigned HDR   = 5;
  localparam int unsigned TAIL  = 2;
  localparam int unsigned LPOS  = 1;
  localparam int unsigned ILEN  = 3;
  localparam int unsigned CLEN  = 6;

  logic [7:0]  sof;
  logic [31:0] tmo;
  logic [7:0]  maxlen;
  logic [15:0] info_id, client_id;
  logic [7:0]  fbuf [DEPTH];
  int unsigned wpos, want_total;
  logic [31:0] last_tick, goods, bads;
  logic        online;
  logic [7:0]  info_rec [ILEN];
  logic [7:0]  client_rec [CLEN];
  logic [1:0]  rec_ok;
  logic [31:0] rec_tick [2];
  out_t        results_due [$];

  assign pending_o = results_due.size();

  function automatic int unsigned buf_u16(int unsigned i);
    return 32'({fbuf[i+1], fbuf[i]});
  endfunction

  function automatic out_t deframe(in_t it);
    out_t r;
    int unsigned lim, tot;
    logic err;
    r = '0;
    err = 1'b0;
    lim = (maxlen > DEPTH) ? DEPTH : maxlen;
    case (func_e'(it.func))
      FUNC_BYTE: begin
        if (wpos >= lim) begin
          bads++; err = 1'b1; wpos = 0; want_total = 0;
        end
        if (wpos < DEPTH) fbuf[wpos] = it.rx_byte;
        wpos++;
        if (fbuf[0] != sof) begin
          bads++; wpos = 0; want_total = 0; r.event_res = EV_ERROR;
        end else if (wpos < HDR) begin
          r.event_res = err ? EV_ERROR : EV_NONE;
        end else begin
          tot = HDR + CMD_LEN + buf_u16(LPOS) + TAIL;
          if (want_total == 0 && tot > lim) begin
            bads++; wpos = 0; want_total = 0; r.event_res = EV_ERROR;
          end else begin
            if (want_total == 0) want_total = tot;
            if (wpos < want_total) begin
              r.event_res = err ? EV_ERROR : EV_NONE;
            end else begin
              r.event_res = EV_FRAME;
              r.frame_cmd = 16'(buf_u16(HDR));
              r.frame_data_len = 16'(buf_u16(LPOS));
              // first record wins when both ids match
              if (r.frame_cmd == info_id && r.frame_data_len >= ILEN) begin
                for (int i = 0; i < ILEN; i++) info_rec[i] = fbuf[HDR+CMD_LEN+i];
                rec_ok[0] = 1'b1; rec_tick[0] = it.cur_tick;
              end else if (r.frame_cmd == client_id && r.frame_data_len >= CLEN) begin
                for (int i = 0; i < CLEN; i++) client_rec[i] = fbuf[HDR+CMD_LEN+i];
                rec_ok[1] = 1'b1; rec_tick[1] = it.cur_tick;
              end
              goods++; last_tick = it.cur_tick; online = 1'b1;
              wpos = 0; want_total = 0;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (online && (it.cur_tick - last_tick) > tmo) online = 1'b0;
      end
      FUNC_READ: begin
        r.event_res = EV_READ;
        if (it.rec_sel == 1'b0) r.rd_data = (it.rec_index < ILEN) ? info_rec[it.rec_index] : 8'd0;
        else r.rd_data = (it.rec_index < CLEN) ? client_rec[it.rec_index] : 8'd0;
        r.rd_valid = rec_ok[it.rec_sel];
        r.rd_stamp = rec_tick[it.rec_sel];
      end
      default: ;
    endcase
    r.link_online = online;
    r.good_frames = goods;
    r.bad_frames = bads;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e, a;
    if (!rst_ni) begin
      sof <= SOF_RST; tmo <= TIMEOUT_RST; maxlen <= MAXLEN_RST;
      info_id <= INFO_RST; client_id <= CLIENT_RST;
      wpos = 0; want_total = 0; last_tick = '0; online = 1'b0;
      goods = '0; bads = '0; rec_ok = '0; rec_tick[0] = '0; rec_tick[1] = '0;
      foreach (fbuf[i]) fbuf[i] = '0;
      foreach (info_rec[i]) info_rec[i] = '0;
      foreach (client_rec[i]) client_rec[i] = '0;
      results_due.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SOF:       sof <= cfg_data_i[7:0];
          CFG_TIMEOUT:   tmo <= cfg_data_i;
          CFG_MAXLEN:    maxlen <= cfg_data_i[7:0];
          CFG_INFO_ID:   info_id <= cfg_data_i[15:0];
          CFG_CLIENT_ID: client_id <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        a = out_data_i;
        if (results_due.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = results_due.pop_front();
          if (a !== e) begin
            fail_count_o <= fail_count_o + 1;
            if (a.event_res !== e.event_res)
              $error("event_res exp %0d got %0d", e.event_res, a.event_res);
            if (a.frame_cmd !== e.frame_cmd)
              $error("frame_cmd exp %0h got %0h", e.frame_cmd, a.frame_cmd);
            if (a.frame_data_len !== e.frame_data_len)
              $error("frame_data_len exp %0d got %0d", e.frame_data_len, a.frame_data_len);
            if (a.link_online !== e.link_online)
              $error("link_online exp %0d got %0d", e.link_online, a.link_online);
            if (a.good_frames !== e.good_frames)
              $error("good_frames exp %0d got %0d", e.good_frames, a.good_frames);
            if (a.bad_frames !== e.bad_frames)
              $error("bad_frames exp %0d got %0d", e.bad_frames, a.bad_frames);
            if (a.rd_data !== e.rd_data)
              $error("rd_data exp %0h got %0h", e.rd_data, a.rd_data);
            if (a.rd_valid !== e.rd_valid)
              $error("rd_valid exp %0d got %0d", e.rd_valid, a.rd_valid);
            if (a.rd_stamp !== e.rd_stamp)
              $error("rd_stamp exp %0h got %0h", e.rd_stamp, a.rd_stamp);
          end
        end
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(deframe(in_data_i));
    end
  end

  final begin
    if (results_due.size() != 0) $error("%0d results never arrived", results_due.size());
  end
endmodule

[test/length_framed_serial_deframer_tb.sv]
module length_framed_serial_deframer_tb;
  import lfsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0, in_stall, out_valid;
  in_t  in_data = '0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  int fails, pending, quiet;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 1'b0;
  logic [31:0] tick_now = 32'd0;
  logic [7:0]  cur_sof = SOF_RST;
  logic [15:0] cur_info = INFO_RST, cur_client = CLIENT_RST;
  logic [7:0]  cur_max = MAXLEN_RST;

  always #4 clk_i = ~clk_i;

  length_framed_serial_deframer uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  length_framed_serial_deframer_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fails), .pending_o(pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one input transaction, with random idle cycles before it
  task automatic push(in_t it);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid = 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic push_byte(logic [7:0] b);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.func = FUNC_BYTE;
    it.rx_byte = b;
    it.cur_tick = tick_now;
    push(it);
  endtask

  task automatic push_tick(logic [31:0] t);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.func = FUNC_TICK;
    it.cur_tick = t;
    push(it);
  endtask

  task automatic push_read(logic sel, logic [2:0] idx);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.func = FUNC_READ;
    it.rec_sel = sel;
    it.rec_index = idx;
    push(it);
  endtask

  // frame, cut short after cut bytes; the header bytes beyond the length field are random
  task automatic push_frame(logic [15:0] cmd, logic [15:0] dlen, int cut);
    int n;
    n = 5 + 2 + dlen + 2;
    for (int i = 0; i < n && i < cut; i++) begin
      if (i == 0) push_byte(cur_sof);
      else if (i == 1) push_byte(dlen[7:0]);
      else if (i == 2) push_byte(dlen[15:8]);
      else if (i == 5) push_byte(cmd[7:0]);
      else if (i == 6) push_byte(cmd[15:8]);
      else push_byte($urandom);
    end
  endtask

  // registers change only once the block has drained
  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_SOF:       cur_sof = val[7:0];
      CFG_MAXLEN:    cur_max = val[7:0];
      CFG_INFO_ID:   cur_info = val[15:0];
      CFG_CLIENT_ID: cur_client = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_cmd();
    case ($urandom_range(3))
      0: return cur_info;
      1: return cur_client;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_mix(int count);
    int k, lim;
    logic [15:0] dl;
    k = 0;
    lim = (cur_max > 9) ? cur_max - 9 : 0;
    while (k < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          // well-formed frame, short data mostly
          dl = ($urandom_range(7) == 0) ? $urandom_range(lim) : $urandom_range(lim < 8 ? lim : 8);
          push_frame(pick_cmd(), dl, 1000);
          k += dl + 9;
        end
        5: begin
          // broken frame: truncated or oversized length
          if ($urandom_range(1)) push_frame(pick_cmd(), $urandom_range(8), $urandom_range(8));
          else push_frame(pick_cmd(), $urandom, 6);
          k += 6;
        end
        6: begin push_byte($urandom); k++; end
        7: begin
          tick_now += $urandom_range(150);
          if ($urandom_range(9) == 0) tick_now = $urandom;
          push_tick(tick_now); k++;
        end
        8: begin push_read($urandom, $urandom); k++; end
        default: begin
          in_t it;
          it = in_t'({$urandom, $urandom});
          if (it.func == FUNC_BYTE) it.func = FUNC_NONE;
          push(it); k++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: read empty records, full frames for both ids, errors, reads, ticks, all-ones input
    push_read(1'b0, 3'd0);
    push_read(1'b1, 3'd7);
    push_frame(INFO_RST, 16'd3, 1000);
    push_frame(CLIENT_RST, 16'd6, 1000);
    push_frame(CLIENT_RST, 16'd5, 1000);
    push_byte(8'h00);
    push_frame(16'hFFFF, 16'hFFFF, 3);
    for (int i = 0; i < 8; i++) push_read(i[0], i[2:0]);
    push_tick(32'd5);
    push_tick(32'hFFFF_FFFF);
    push_tick(32'd0);
    begin
      in_t it;
      it = '1;
      push(it);
    end

    // max-length frame, overflow past a small limit, wrap of the tick difference
    drain();
    cfg_write(CFG_MAXLEN, 8'd255);
    push_frame(INFO_RST, 16'd119, 1000);
    drain();
    cfg_write(CFG_MAXLEN, 8'd12);
    cfg_write(CFG_SOF, 8'hFF);
    cfg_write(CFG_TIMEOUT, 32'hFFFF_FFFF);
    push_frame(16'h1234, 16'd3, 1000);
    push_frame(16'h1234, 16'd9, 1000);
    push_frame(16'h1234, 16'd3, 5);
    for (int i = 0; i < 14; i++) push_byte(8'hFF);
    push_tick(32'd3);
    drain();
    cfg_write(CFG_MAXLEN, 8'd0);
    push_byte(8'hFF);
    push_byte(8'h00);
    drain();

    // random phases under several settings and idling profiles
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_write(CFG_SOF, (ph == 1) ? 8'h00 : $urandom);
      cfg_write(CFG_TIMEOUT, (ph == 2) ? 32'd0 : $urandom_range(300));
      cfg_write(CFG_MAXLEN, (ph == 3) ? 8'd1 : (ph == 4) ? 8'd128 : $urandom_range(20, 60));
      cfg_write(CFG_INFO_ID, (ph == 5) ? 16'hFFFF : $urandom);
      cfg_write(CFG_CLIENT_ID, (ph == 5) ? 16'hFFFF : (ph == 0) ? 16'h0000 : $urandom);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      random_mix(200);
      if (ph == 2) begin
        // long receiver hold-off while frames keep coming
        hold_off = 1'b1;
        fork
          begin repeat (300) @(negedge clk_i); hold_off = 1'b0; end
          random_mix(40);
        join
        // sender waits for every result
        while (pending != 0) @(negedge clk_i);
        random_mix(20);
      end
    end

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
